[sv/tspsa_pkg.sv]
// shared types and constants for the transport stream packet sync aligner
// no dependencies; imported by every module of the block
`default_nettype none

package tspsa_pkg;

    // default geometry of the delay line
    localparam int PKT_LEN_DEF      = 188;
    localparam int SYNC_PACKETS_DEF = 4;

    // sync byte after reset
    localparam logic [7:0] SYNC_RESET = 8'h47;

    // output queue
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_IDX_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    // register port
    localparam int PADDR_W   = 3;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_SYNC_VALUE = REG_IDX_W'(0);

    // one output word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_start;
        logic       packet_end;
    } out_word_t;

    // control of the decision stage
    typedef struct packed {
        logic valid;   // a word is in the decision stage
        logic decide;  // delay line was full, oldest byte gets a verdict
    } s1_ctl_t;

endpackage

`default_nettype wire

[sv/tspsa_if.sv]
// stream channel interfaces for the packet sync aligner
// no dependencies
`default_nettype none

interface tspsa_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface tspsa_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       packet_start;
    logic       packet_end;

    modport source (output valid, output out_byte, output packet_start,
                    output packet_end, input ready);
    modport sink   (input valid, input out_byte, input packet_start,
                    input packet_end, output ready);
endinterface

`default_nettype wire

[sv/ts_packet_sync_aligner_top.sv]
// transport stream packet sync aligner, top level
// a forwarded byte is registered in the decision stage and then written into the output queue before it can be accepted
// throughput: one word per cycle; in_ch.ready drops while queued plus in-flight words reach 4
// the first PKT_LEN*SYNC_PACKETS-1 words fill the delay line and give no output
// reset (rst_n, async, active low) clears pointers, fill, lock and queue; memory is not cleared
`default_nettype none

module ts_packet_sync_aligner_top
    import tspsa_pkg::*;
#(
    parameter int PKT_LEN      = PKT_LEN_DEF,
    parameter int SYNC_PACKETS = SYNC_PACKETS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    tspsa_in_if.sink                in_ch,
    tspsa_out_if.source             out_ch,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    logic                         push;
    logic                         space_ok;
    logic [7:0]                   sync_value;
    s1_ctl_t                      s1_ctl;
    wire [SYNC_PACKETS-1:0][7:0]  look_bytes;
    logic                         emit;
    out_word_t                    emit_word;
    logic                         head_valid;
    out_word_t                    head_word;
    logic                         pop;

    // a word is taken whenever the queue has room for it and the word ahead of it
    assign in_ch.ready = space_ok;
    assign push        = in_ch.valid & space_ok;
    assign pop         = head_valid & out_ch.ready;

    // sync byte register
    tspsa_apb_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .sync_value (sync_value)
    );

    // delay line: one memory with a byte lane per packet length, shifted through
    // a circular pointer; also reads the packet boundary bytes for the verdict
    tspsa_delay_line #(
        .PKT_LEN      (PKT_LEN),
        .SYNC_PACKETS (SYNC_PACKETS)
    ) u_line (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_byte  (in_ch.data_byte),
        .s1_ctl     (s1_ctl),
        .look_bytes (look_bytes)
    );

    // lock state and framing, one verdict per cycle on the oldest byte while input words are taken
    tspsa_sync_ctrl #(
        .PKT_LEN      (PKT_LEN),
        .SYNC_PACKETS (SYNC_PACKETS)
    ) u_sync (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_ctl     (s1_ctl),
        .look_bytes (look_bytes),
        .sync_value (sync_value),
        .emit       (emit),
        .emit_word  (emit_word)
    );

    // output queue decouples the output handshake from the pipeline
    tspsa_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_flight  (s1_ctl.valid),
        .push       (emit),
        .push_word  (emit_word),
        .pop        (pop),
        .space_ok   (space_ok),
        .head_valid (head_valid),
        .head_word  (head_word)
    );

    assign out_ch.valid        = head_valid;
    assign out_ch.out_byte     = head_word.out_byte;
    assign out_ch.packet_start = head_word.packet_start;
    assign out_ch.packet_end   = head_word.packet_end;

endmodule

`default_nettype wire

[sv/tspsa_apb_regs.sv]
// apb register block holding the sync byte
// depends on tspsa_pkg
`default_nettype none

module tspsa_apb_regs
    import tspsa_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    output logic      [7:0]         sync_value
);

    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    logic [7:0]           sync_reg;
    logic [7:0]           sync_next;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        sync_next = sync_reg;
        prdata    = 32'd0;
        unique case (reg_idx)
            REG_SYNC_VALUE:
            begin
                prdata = {24'd0, sync_reg};
                if (wr_en)
                begin
                    sync_next = pwdata[7:0];
                end
            end
            default:
            begin
                prdata = 32'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg <= SYNC_RESET;
        end
        else
        begin
            sync_reg <= sync_next;
        end
    end

    assign sync_value = sync_reg;

endmodule

`default_nettype wire

[sv/tspsa_delay_line.sv]
// segmented delay line: one circular memory, one byte lane per packet length
// depends on tspsa_pkg
`default_nettype none

module tspsa_delay_line
    import tspsa_pkg::*;
#(
    parameter int PKT_LEN      = PKT_LEN_DEF,
    parameter int SYNC_PACKETS = SYNC_PACKETS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    input  wire logic [7:0]                   push_byte,
    output s1_ctl_t                           s1_ctl,
    output wire logic [SYNC_PACKETS-1:0][7:0] look_bytes
);

    localparam int WINDOW_LEN = PKT_LEN * SYNC_PACKETS;
    localparam int PTR_W      = $clog2(PKT_LEN);
    localparam int FILL_W     = $clog2(WINDOW_LEN);
    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(PKT_LEN - 1);
    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(WINDOW_LEN - 1);

    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [PTR_W-1:0]  look_ptr_reg, look_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              s1_valid_reg, s1_decide_reg;
    logic [PTR_W-1:0]  s1_addr_reg;
    logic [7:0]        s1_byte_reg;
    logic              full;

    // lane g of an entry holds the byte g packet lengths after lane 0
    logic [SYNC_PACKETS-1:0][7:0] line_mem [PKT_LEN];
    logic [SYNC_PACKETS-1:0][7:0] look_rd_reg;
    logic [SYNC_PACKETS-1:1][7:0] shift_rd_reg;
    logic [SYNC_PACKETS-1:0][7:0] wr_word;

    assign full = (fill_reg == FILL_LAST);

    always_comb
    begin
        ptr_next      = ptr_reg;
        look_ptr_next = look_ptr_reg;
        fill_next     = fill_reg;
        if (push)
        begin
            ptr_next      = look_ptr_reg;
            look_ptr_next = (look_ptr_reg == PTR_LAST) ? '0 : look_ptr_reg + 1'b1;
            if (!full)
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            look_ptr_reg  <= PTR_W'(1);
            fill_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            s1_decide_reg <= 1'b0;
        end
        else
        begin
            ptr_reg       <= ptr_next;
            look_ptr_reg  <= look_ptr_next;
            fill_reg      <= fill_next;
            s1_valid_reg  <= push;
            s1_decide_reg <= push & full;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            s1_addr_reg <= ptr_reg;
            s1_byte_reg <= push_byte;
        end
    end

    // newest lane takes the new byte, every other lane takes the one above it
    assign wr_word = {s1_byte_reg, shift_rd_reg};

    // write-back lands in the cycle after the read; the next reads are at least one
    // entry further on, so the memory never reads an entry with a write pending
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            line_mem[s1_addr_reg] <= wr_word;
        end
        if (push)
        begin
            look_rd_reg  <= line_mem[look_ptr_reg];
            shift_rd_reg <= line_mem[ptr_reg][SYNC_PACKETS-1:1];
        end
    end

    assign look_bytes    = look_rd_reg;
    assign s1_ctl.valid  = s1_valid_reg;
    assign s1_ctl.decide = s1_decide_reg;

endmodule

`default_nettype wire

[sv/tspsa_sync_ctrl.sv]
// lock tracking and packet framing on the oldest byte of the window
// depends on tspsa_pkg
`default_nettype none

module tspsa_sync_ctrl
    import tspsa_pkg::*;
#(
    parameter int PKT_LEN      = PKT_LEN_DEF,
    parameter int SYNC_PACKETS = SYNC_PACKETS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire s1_ctl_t                      s1_ctl,
    input  wire logic [SYNC_PACKETS-1:0][7:0] look_bytes,
    input  wire logic [7:0]                   sync_value,
    output logic                              emit,
    output out_word_t                         emit_word
);

    localparam int POS_W = $clog2(PKT_LEN);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(PKT_LEN - 1);

    logic             locked_reg, locked_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             run_found;
    logic             start;

    always_comb
    begin
        run_found = 1'b1;
        for (int k = 0; k < SYNC_PACKETS; k++)
        begin
            if (look_bytes[k] != sync_value)
            begin
                run_found = 1'b0;
            end
        end
    end

    always_comb
    begin
        locked_next = locked_reg;
        pos_next    = pos_reg;
        emit        = 1'b0;
        start       = 1'b0;
        if (s1_ctl.valid && s1_ctl.decide)
        begin
            if (locked_reg && pos_reg != '0)
            begin
                emit = 1'b1;
            end
            else if (locked_reg)
            begin
                if (look_bytes[0] == sync_value)
                begin
                    emit  = 1'b1;
                    start = 1'b1;
                end
                else
                begin
                    locked_next = 1'b0;
                    pos_next    = '0;
                end
            end
            else if (run_found)
            begin
                locked_next = 1'b1;
                emit        = 1'b1;
                start       = 1'b1;
            end
            if (emit)
            begin
                pos_next = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            locked_reg <= 1'b0;
            pos_reg    <= '0;
        end
        else
        begin
            locked_reg <= locked_next;
            pos_reg    <= pos_next;
        end
    end

    assign emit_word.out_byte     = look_bytes[0];
    assign emit_word.packet_start = start;
    assign emit_word.packet_end   = (pos_reg == POS_LAST);

endmodule

`default_nettype wire

[sv/tspsa_out_queue.sv]
// small output queue with credit check against the word in flight
// depends on tspsa_pkg
`default_nettype none

module tspsa_out_queue
    import tspsa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_flight,
    input  wire logic      push,
    input  wire out_word_t push_word,
    input  wire logic      pop,
    output logic           space_ok,
    output logic           head_valid,
    output out_word_t      head_word
);

    localparam logic [OUTQ_IDX_W-1:0] IDX_LAST = OUTQ_IDX_W'(OUTQ_DEPTH - 1);

    out_word_t             q_mem_reg [OUTQ_DEPTH];
    logic [OUTQ_IDX_W-1:0] head_reg, head_next;
    logic [OUTQ_IDX_W-1:0] tail_reg, tail_next;
    logic [OUTQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic [OUTQ_CNT_W:0]   committed;

    // queued words plus the one still in the decision stage
    assign committed = {1'b0, cnt_reg} + {{OUTQ_CNT_W{1'b0}}, in_flight};
    assign space_ok  = (committed < (OUTQ_CNT_W+1)'(OUTQ_DEPTH));

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            tail_next = (tail_reg == IDX_LAST) ? '0 : tail_reg + 1'b1;
        end
        if (pop)
        begin
            head_next = (head_reg == IDX_LAST) ? '0 : head_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[tail_reg] <= push_word;
        end
    end

    assign head_valid = (cnt_reg != '0);
    assign head_word  = q_mem_reg[head_reg];

endmodule

`default_nettype wire

[bench/tspsa_align_checker.sv]
`timescale 1ns / 1ps
// watches the byte channels and the register port of the packet sync aligner, predicts
// the aligned words and compares them; depends on tspsa_pkg and the channel interfaces
module tspsa_align_checker
    import tspsa_pkg::*;
#(
    parameter int PKT_LEN      = PKT_LEN_DEF,
    parameter int SYNC_PACKETS = SYNC_PACKETS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    tspsa_in_if                     in_ch,
    tspsa_out_if                    out_ch,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic               pready,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    input  wire logic [31:0]        prdata,
    output int                      fail_count,
    output int                      pending
);

    localparam int LINE_LEN = PKT_LEN * SYNC_PACKETS;

    logic [7:0] line_bytes[$];   // delay line, oldest byte first
    out_word_t  due_words[$];    // aligned words still to come out
    logic [7:0] exp_sync;
    logic       in_lock;
    logic [7:0] pos_in_pkt;

    // oldest byte and the ones whole packet lengths after it all carry the sync byte
    function automatic logic sync_run_seen();
        for (int k = 0; k < SYNC_PACKETS; k++)
            if (line_bytes[k * PKT_LEN] != exp_sync)
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic advance_line(input logic [7:0] b);
        logic [7:0] oldest;
        logic       emit;
        logic       first;
        logic       last;
        out_word_t  w;
        line_bytes.push_back(b);
        if (line_bytes.size() < LINE_LEN)
            return;
        oldest = line_bytes[0];
        emit   = 1'b0;
        first  = 1'b0;
        last   = 1'b0;
        if (in_lock && pos_in_pkt != 8'd0)
        begin
            emit = 1'b1;
        end
        else if (in_lock)
        begin
            if (oldest == exp_sync)
            begin
                emit  = 1'b1;
                first = 1'b1;
            end
            else
            begin
                // sync miss: drop the byte and search again
                in_lock    = 1'b0;
                pos_in_pkt = 8'd0;
            end
        end
        else if (sync_run_seen())
        begin
            in_lock    = 1'b1;
            pos_in_pkt = 8'd0;
            emit       = 1'b1;
            first      = 1'b1;
        end
        if (emit)
        begin
            if (int'(pos_in_pkt) + 1 >= PKT_LEN)
            begin
                last       = 1'b1;
                pos_in_pkt = 8'd0;
            end
            else
            begin
                pos_in_pkt = pos_in_pkt + 8'd1;
            end
            w.out_byte     = oldest;
            w.packet_start = first;
            w.packet_end   = last;
            due_words.push_back(w);
        end
        void'(line_bytes.pop_front());
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        int        errs;
        out_word_t want;
        if (!rst_n)
        begin
            line_bytes.delete();
            due_words.delete();
            exp_sync   = SYNC_RESET;
            in_lock    = 1'b0;
            pos_in_pkt = 8'd0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            errs = 0;
            if (psel && penable && pready && paddr[PADDR_W-1:2] == REG_SYNC_VALUE)
            begin
                if (pwrite)
                begin
                    exp_sync = pwdata[7:0];
                end
                else if (prdata !== {24'd0, exp_sync})
                begin
                    $display("%0t: sync_value read expected %08h actual %08h",
                             $time, {24'd0, exp_sync}, prdata);
                    errs++;
                end
            end
            // outputs first, so a word can never match an expectation made at this edge
            if (out_ch.valid && out_ch.ready)
            begin
                if (due_words.size() == 0)
                begin
                    $display("%0t: word %02h start %b end %b with nothing expected", $time,
                             out_ch.out_byte, out_ch.packet_start, out_ch.packet_end);
                    errs++;
                end
                else
                begin
                    want = due_words.pop_front();
                    if (out_ch.out_byte !== want.out_byte)
                    begin
                        $display("%0t: out_byte expected %02h actual %02h",
                                 $time, want.out_byte, out_ch.out_byte);
                        errs++;
                    end
                    if (out_ch.packet_start !== want.packet_start)
                    begin
                        $display("%0t: packet_start expected %b actual %b",
                                 $time, want.packet_start, out_ch.packet_start);
                        errs++;
                    end
                    if (out_ch.packet_end !== want.packet_end)
                    begin
                        $display("%0t: packet_end expected %b actual %b",
                                 $time, want.packet_end, out_ch.packet_end);
                        errs++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                advance_line(in_ch.data_byte);
            fail_count <= fail_count + errs;
            pending    <= due_words.size();
        end
    end

endmodule

[bench/ts_packet_sync_aligner_top_tb.sv]
`timescale 1ns / 1ps
// stimulus and verdict for the transport stream packet sync aligner
// depends on tspsa_pkg, the channel interfaces, the aligner rtl and tspsa_align_checker
module ts_packet_sync_aligner_top_tb;
    import tspsa_pkg::*;

    localparam int PKT_LEN      = PKT_LEN_DEF;
    localparam int SYNC_PACKETS = SYNC_PACKETS_DEF;

    // register map: byte address is index times four
    localparam logic [REG_IDX_W-1:0] REG_SPARE       = REG_IDX_W'(REG_SYNC_VALUE + 1);
    localparam logic [PADDR_W-1:0]   ADDR_SYNC_VALUE = {REG_SYNC_VALUE, 2'b00};
    localparam logic [PADDR_W-1:0]   ADDR_SPARE      = {REG_SPARE, 2'b00};

    // every frame but a bad-header one carries three markers, so each sync setting has an alignment to find
    localparam logic [7:0] SYNC_HI   = 8'hFF;
    localparam logic [7:0] SYNC_LO   = 8'h00;
    localparam int         HI_OFFSET = PKT_LEN / 8;
    localparam int         LO_OFFSET = PKT_LEN / 4;

    // random part: switch sync setting while locked, words counted from its start
    localparam int RANDOM_WORDS = 1040;
    localparam int HI_SWITCH_AT = 760;
    localparam int LO_SWITCH_AT = 990;
    localparam int SETTLE_CYCLES = 8;

    // lead-in: field extremes, alternating bit patterns and stray sync bytes
    localparam int LEAD_LEN = 12;
    localparam logic [LEAD_LEN*8-1:0] LEAD_IN = {8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80,
                                                 8'h7F, 8'hFE, SYNC_RESET, SYNC_RESET,
                                                 SYNC_LO, SYNC_HI};

    typedef enum int {RX_OPEN, RX_LIGHT, RX_HALF, RX_HEAVY} rx_mode_t;

    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;
    int                 fail_count;
    int                 pending;

    tspsa_in_if  in_ch ();
    tspsa_out_if out_ch ();

    ts_packet_sync_aligner_top #(
        .PKT_LEN      (PKT_LEN),
        .SYNC_PACKETS (SYNC_PACKETS)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tspsa_align_checker #(
        .PKT_LEN      (PKT_LEN),
        .SYNC_PACKETS (SYNC_PACKETS)
    ) sync_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver: back-pressure mode is picked at random for runs of random length
    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;

    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_left <= $urandom_range(16, 200);
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        end
        else
        begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:  out_ch.ready <= 1'b1;                          // no stalls at all
            RX_LIGHT: out_ch.ready <= ($urandom_range(0, 3) != 0);
            RX_HALF:  out_ch.ready <= ($urandom_range(0, 1) == 1);
            default:  out_ch.ready <= ($urandom_range(0, 15) == 0);  // long stalls
        endcase
    end

    // sender: bursts of random length, gaps of random length in between
    int burst_left = 0;

    task automatic send_word(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            else if ($urandom_range(0, 15) == 0)
                gap = $urandom_range(20, 40);
            else
                gap = $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        do @(posedge clk); while (!in_ch.ready);
        burst_left--;
    endtask

    // stop sending and wait until every expected word is out and the pipe is empty
    task automatic settle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one apb transfer: setup, access, then back to idle
    task automatic reg_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int         sent;
        int         frame_pos;
        int         frame_len;
        logic       hdr_bad;
        logic [7:0] b;

        in_ch.valid     = 1'b0;
        in_ch.data_byte = 8'h00;
        out_ch.ready    = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // write to the unused index must be ignored, sync_value still reads its reset value
        reg_access(1'b1, ADDR_SPARE, $urandom);
        reg_access(1'b0, ADDR_SYNC_VALUE, '0);

        // lead-in bytes all fall out of the line while the search runs
        for (int i = LEAD_LEN - 1; i >= 0; i--)
            send_word(LEAD_IN[8*i +: 8]);

        // random frames with all three markers; a few frames are broken on purpose
        sent      = 0;
        frame_pos = 0;
        frame_len = PKT_LEN;
        hdr_bad   = 1'b0;
        while (sent < RANDOM_WORDS)
        begin
            // change of sync setting while locked: the packet in flight finishes, the
            // next header misses, and the search settles on the other marker
            if (sent == HI_SWITCH_AT || sent == LO_SWITCH_AT)
            begin
                settle();
                reg_access(1'b1, ADDR_SYNC_VALUE,
                           {24'($urandom), (sent == HI_SWITCH_AT) ? SYNC_HI : SYNC_LO});
                reg_access(1'b0, ADDR_SYNC_VALUE, '0);
            end
            if (frame_pos == 0)
            begin
                frame_len = PKT_LEN;
                hdr_bad   = 1'b0;
                case ($urandom_range(0, 63))
                    0:       hdr_bad = 1'b1;                               // bad header
                    1:       frame_len = PKT_LEN - $urandom_range(1, 3);   // short frame
                    2:       frame_len = PKT_LEN + $urandom_range(1, 3);   // stray bytes
                    default: ;
                endcase
            end
            if (frame_pos == 0)
                b = hdr_bad ? (SYNC_RESET ^ 8'($urandom_range(1, 255))) : SYNC_RESET;
            else if (frame_pos == HI_OFFSET)
                b = SYNC_HI;
            else if (frame_pos == LO_OFFSET)
                b = SYNC_LO;
            else
            begin
                // payload, now and then a marker value in the wrong place
                case ($urandom_range(0, 31))
                    0:       b = SYNC_RESET;
                    1:       b = SYNC_HI;
                    2:       b = SYNC_LO;
                    default: b = 8'($urandom);
                endcase
            end
            send_word(b);
            sent++;
            frame_pos = (frame_pos + 1 >= frame_len) ? 0 : frame_pos + 1;
        end

        settle();
        @(negedge clk);
        if (pending != 0)
            $display("%0t: %0d expected words never came out", $time, pending);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
